FILE: src/ktrk_pkg.sv
`timescale 1ns / 1ps
package ktrk_pkg;

  localparam int MAX_K = 64;
  localparam int DataW = 32;
  localparam int KW    = 7;
  localparam int IdxW  = $clog2(MAX_K);
  localparam int CntW  = IdxW + 1;
  localparam int ChW   = IdxW + 2;
  localparam int StepW = 4;

  typedef logic [StepW-1:0] step_t;

  localparam step_t ST_IDLE  = 4'd0;
  localparam step_t ST_BR    = 4'd1;
  localparam step_t ST_UINIT = 4'd2;
  localparam step_t ST_UTEST = 4'd3;
  localparam step_t ST_UCMP  = 4'd4;
  localparam step_t ST_DCMP  = 4'd5;
  localparam step_t ST_DL    = 4'd6;
  localparam step_t ST_DR    = 4'd7;
  localparam step_t ST_DPICK = 4'd8;
  localparam step_t ST_WRITE = 4'd9;
  localparam step_t ST_OUT   = 4'd10;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_UINIT,
    OP_RD_PAR,
    OP_UMOVE,
    OP_DSTART,
    OP_RD_L,
    OP_RD_R,
    OP_DMOVE,
    OP_WR_V,
    OP_LOAD_OUT
  } uop_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_ACC,
    C_FULL,
    C_POS_ZERO,
    C_V_LT_RD,
    C_ROOT_LT_V,
    C_L_GE_N,
    C_PICK_LT_V,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t tgt_t;
    step_t tgt_f;
  } ucode_t;

  typedef struct packed {
    uop_e op;
    logic hit;
  } ctrl_t;

  typedef struct packed {
    logic in_acc;
    logic full;
    logic pos_zero;
    logic v_lt_rd;
    logic root_lt_v;
    logic l_ge_n;
    logic pick_lt_v;
    logic out_free;
  } stat_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      ST_IDLE:  w = '{OP_ACCEPT,   C_IN_ACC,    ST_BR,    ST_IDLE};
      ST_BR:    w = '{OP_NOP,      C_FULL,      ST_DCMP,  ST_UINIT};
      ST_UINIT: w = '{OP_UINIT,    C_ALWAYS,    ST_UTEST, ST_UTEST};
      ST_UTEST: w = '{OP_RD_PAR,   C_POS_ZERO,  ST_WRITE, ST_UCMP};
      ST_UCMP:  w = '{OP_UMOVE,    C_V_LT_RD,   ST_UTEST, ST_WRITE};
      ST_DCMP:  w = '{OP_DSTART,   C_ROOT_LT_V, ST_DL,    ST_OUT};
      ST_DL:    w = '{OP_RD_L,     C_L_GE_N,    ST_WRITE, ST_DR};
      ST_DR:    w = '{OP_RD_R,     C_ALWAYS,    ST_DPICK, ST_DPICK};
      ST_DPICK: w = '{OP_DMOVE,    C_PICK_LT_V, ST_DL,    ST_WRITE};
      ST_WRITE: w = '{OP_WR_V,     C_ALWAYS,    ST_OUT,   ST_OUT};
      ST_OUT:   w = '{OP_LOAD_OUT, C_OUT_FREE,  ST_IDLE,  ST_OUT};
      default:  w = '{OP_NOP,      C_ALWAYS,    ST_IDLE,  ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: src/kth_largest_stream_tracker_unit.sv
`timescale 1ns / 1ps
// Per accepted word: while the heap is not full it is appended and sifted up; when full, a
// word not larger than the root is dropped, else it replaces the root and sifts down to a
// leaf or until no child is smaller.
// The unit takes one word at a time; a result waits in an output register and holds off
// the next word.
// Reset: k = 1, heap empty. A k write empties the heap.
module kth_largest_stream_tracker_unit import ktrk_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] kth_value_o,
  output logic                    heap_full_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [KW-1:0]           k_target_i
);

  ctrl_t ctrl;
  stat_t stat;

  ktrk_useq u_useq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  ktrk_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kth_value_o(kth_value_o),
    .heap_full_o(heap_full_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .k_target_i (k_target_i)
  );

endmodule

FILE: src/ktrk_ram.sv
`timescale 1ns / 1ps
module ktrk_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ktrk_useq.sv
`timescale 1ns / 1ps
module ktrk_useq import ktrk_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  step_t  step_q, step_d;
  ucode_t uw;
  logic   hit;

  always_comb begin
    uw = ucode_rom(step_q);
    case (uw.cond)
      C_ALWAYS:    hit = 1'b1;
      C_IN_ACC:    hit = stat_i.in_acc;
      C_FULL:      hit = stat_i.full;
      C_POS_ZERO:  hit = stat_i.pos_zero;
      C_V_LT_RD:   hit = stat_i.v_lt_rd;
      C_ROOT_LT_V: hit = stat_i.root_lt_v;
      C_L_GE_N:    hit = stat_i.l_ge_n;
      C_PICK_LT_V: hit = stat_i.pick_lt_v;
      C_OUT_FREE:  hit = stat_i.out_free;
      default:     hit = 1'b0;
    endcase
    step_d = hit ? uw.tgt_t : uw.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = '{op: uw.op, hit: hit};

endmodule

FILE: src/ktrk_dpath.sv
`timescale 1ns / 1ps
module ktrk_dpath import ktrk_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  output stat_t                   stat_o,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] kth_value_o,
  output logic                    heap_full_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [KW-1:0]           k_target_i
);

  logic [KW-1:0]           k_q;
  logic [CntW-1:0]         count_q, cap;
  logic [IdxW-1:0]         pos_q, par;
  logic signed [DataW-1:0] v_q, root_q, ldata_q, kth_q;
  logic                    rvalid_q, out_valid_q, full_q;
  logic [ChW-1:0]          lidx, ridx;
  logic                    cfg_we, in_acc, full;
  logic signed [DataW-1:0] rdata, pickval;
  logic [IdxW-1:0]         pickidx;
  logic                    we;
  logic [IdxW-1:0]         waddr, raddr;
  logic signed [DataW-1:0] wdata;

  always_comb begin
    if (k_q == '0) begin
      cap = CntW'(1);
    end else if (int'(k_q) > MAX_K) begin
      cap = CntW'(MAX_K);
    end else begin
      cap = CntW'(k_q);
    end
  end

  assign full        = count_q >= cap;
  assign cfg_ready_o = ctrl_i.op == OP_ACCEPT;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (ctrl_i.op != OP_ACCEPT) || cfg_valid_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  assign par  = IdxW'((pos_q - IdxW'(1)) >> 1);
  assign lidx = {1'b0, pos_q, 1'b1};
  assign ridx = lidx + ChW'(1);

  always_comb begin
    if (rvalid_q && (rdata < ldata_q)) begin
      pickval = rdata;
      pickidx = ridx[IdxW-1:0];
    end else begin
      pickval = ldata_q;
      pickidx = lidx[IdxW-1:0];
    end
  end

  always_comb begin
    case (ctrl_i.op)
      OP_RD_PAR: raddr = par;
      OP_RD_L:   raddr = lidx[IdxW-1:0];
      OP_RD_R:   raddr = ridx[IdxW-1:0];
      default:   raddr = lidx[IdxW-1:0];
    endcase
    we    = 1'b0;
    waddr = pos_q;
    wdata = v_q;
    case (ctrl_i.op)
      OP_UMOVE: begin
        we    = ctrl_i.hit;
        wdata = rdata;
      end
      OP_DMOVE: begin
        we    = ctrl_i.hit;
        wdata = pickval;
      end
      OP_WR_V: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  ktrk_ram #(
    .Width(DataW),
    .Depth(MAX_K)
  ) u_heap (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    stat_o.in_acc    = in_acc;
    stat_o.full      = full;
    stat_o.pos_zero  = pos_q == '0;
    stat_o.v_lt_rd   = v_q < rdata;
    stat_o.root_lt_v = root_q < v_q;
    stat_o.l_ge_n    = lidx >= ChW'(count_q);
    stat_o.pick_lt_v = pickval < v_q;
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= KW'(1);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        k_q     <= k_target_i;
        count_q <= '0;
      end else if (ctrl_i.op == OP_UINIT) begin
        count_q <= count_q + CntW'(1);
      end
      if (ctrl_i.op == OP_LOAD_OUT && ctrl_i.hit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q <= value_i;
    end
    if (we && waddr == '0) begin
      root_q <= wdata;
    end
    case (ctrl_i.op)
      OP_UINIT: pos_q <= count_q[IdxW-1:0];
      OP_UMOVE: begin
        if (ctrl_i.hit) begin
          pos_q <= par;
        end
      end
      OP_DSTART: pos_q <= '0;
      OP_RD_R: begin
        ldata_q  <= rdata;
        rvalid_q <= ridx < ChW'(count_q);
      end
      OP_DMOVE: begin
        if (ctrl_i.hit) begin
          pos_q <= pickidx;
        end
      end
      OP_LOAD_OUT: begin
        if (ctrl_i.hit) begin
          kth_q  <= root_q;
          full_q <= full;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign kth_value_o = kth_q;
  assign heap_full_o = full_q;

endmodule

FILE: verif/kth_largest_stream_tracker_unit_tb.sv
`timescale 1ns / 1ps
module kth_largest_stream_tracker_unit_tb;
  import ktrk_pkg::*;

  localparam int RstCycles = 11;
  localparam int SettleCycles = 30;
  localparam int WatchdogLimit = 3000;
  localparam int PhaseItems = 85;
  localparam int LongHold = 400;
  localparam logic signed [DataW-1:0] VMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] VMax = {1'b0, {(DataW-1){1'b1}}};

  typedef struct {
    logic signed [DataW-1:0] kth;
    logic                    full;
  } kth_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [DataW-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b1;
  logic signed [DataW-1:0] kth_value_o;
  logic                    heap_full_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [KW-1:0]           k_target_i = '0;

  kth_largest_stream_tracker_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kth_value_o(kth_value_o),
    .heap_full_o(heap_full_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .k_target_i (k_target_i)
  );

  // predictor state
  logic signed [DataW-1:0] heap_m [MAX_K];
  int unsigned             heap_n = 0;
  logic [KW-1:0]           k_m = 7'd1;

  logic signed [DataW-1:0] value_pending_q [$];
  kth_word_t               kth_expected_q [$];

  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  int  rx_hold = 0;
  bit  in_fire_q = 1'b0;
  int  n_words = 0;
  int  n_results = 0;
  int  n_kwrites = 0;
  int  n_full = 0;
  int  n_errors = 0;
  logic signed [DataW-1:0] ramp_v = '0;

  function automatic kth_word_t heap_insert_predict(input logic signed [DataW-1:0] v);
    int unsigned cap, pos, par, l, r, pick;
    logic signed [DataW-1:0] tmp;
    kth_word_t res;
    cap = k_m;
    if (cap < 1) cap = 1;
    if (cap > MAX_K) cap = MAX_K;
    if (heap_n > cap) heap_n = cap;
    if (heap_n >= cap) begin
      if (heap_m[0] < v) begin
        heap_m[0] = v;
        pos = 0;
        while (1) begin
          l = 2 * pos + 1;
          r = l + 1;
          if (l >= heap_n) break;
          pick = l;
          if (r < heap_n && heap_m[r] < heap_m[l]) pick = r;
          if (!(heap_m[pick] < heap_m[pos])) break;
          tmp = heap_m[pick];
          heap_m[pick] = heap_m[pos];
          heap_m[pos] = tmp;
          pos = pick;
        end
      end
    end else begin
      heap_m[heap_n] = v;
      pos = heap_n;
      while (pos > 0) begin
        par = (pos - 1) / 2;
        if (!(heap_m[pos] < heap_m[par])) break;
        tmp = heap_m[par];
        heap_m[par] = heap_m[pos];
        heap_m[pos] = tmp;
        pos = par;
      end
      heap_n++;
    end
    res.kth = heap_m[0];
    res.full = (heap_n >= cap);
    return res;
  endfunction

  function automatic logic signed [DataW-1:0] random_value();
    int sel;
    logic signed [DataW-1:0] v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = $urandom;
    end else if (sel < 70) begin
      v = $urandom_range(8);
      v = v - 4;
    end else if (sel < 85) begin
      case ($urandom_range(6))
        0: v = VMin;
        1: v = VMin + 1;
        2: v = -1;
        3: v = 0;
        4: v = 1;
        5: v = VMax - 1;
        default: v = VMax;
      endcase
    end else begin
      ramp_v = ramp_v + $urandom_range(1000, 1);
      v = ramp_v;
    end
    return v;
  endfunction

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_fire_q)) begin
      if (value_pending_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid_i <= 1'b1;
        value_i <= value_pending_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // monitor: check results, then predict accepted words
  always @(posedge clk_i) begin
    kth_word_t e;
    in_fire_q = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (kth_expected_q.size() == 0) begin
        $error("unexpected result: kth_value %0d heap_full %0b", kth_value_o, heap_full_o);
        n_errors++;
      end else begin
        e = kth_expected_q.pop_front();
        if (kth_value_o !== e.kth) begin
          $error("kth_value: expected %0d, got %0d", e.kth, kth_value_o);
          n_errors++;
        end
        if (heap_full_o !== e.full) begin
          $error("heap_full: expected %0b, got %0b", e.full, heap_full_o);
          n_errors++;
        end
        if (e.full) n_full++;
      end
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      k_m = k_target_i;
      heap_n = 0;
      n_kwrites++;
    end
    if (in_fire_q) begin
      kth_expected_q.push_back(heap_insert_predict(value_i));
      void'(value_pending_q.pop_front());
      n_words++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    int quiet;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("timeout: %0d cycles without a handshake", quiet);
        $display("** kth_largest_stream_tracker_unit: FAILED **");
        $finish;
      end
    end
  end

  task automatic drain_all();
    do @(posedge clk_i); while (value_pending_q.size() != 0 || kth_expected_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_k(input logic [KW-1:0] k);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    k_target_i <= k;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_mode(input int mode);
    case (mode)
      1: begin tx_idle_pct = 82; rx_stall_pct = 0; end
      2: begin tx_idle_pct = 0; rx_stall_pct = 82; end
      3: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
    endcase
  endtask

  initial begin
    logic [KW-1:0] k_plan [12];
    k_plan = '{7'd64, 7'd0, 7'd127, 7'd2, 7'd5, 7'd5,
               7'd64, 7'd33, 7'd65, 7'd16, 7'd7, 7'd1};
    repeat (RstCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mode(0);

    // k = 1 from reset: extremes, ties at the root
    value_pending_q = '{VMin, VMin, VMax, 0, -1, VMax};
    drain_all();

    // k = 4: fill, drop smaller and equal, replace root
    write_k(7'd4);
    value_pending_q = '{10, 20, 30, 40, -5, 10, 15, 25, 25, VMax, VMin};
    drain_all();

    // k = 3: descending fill sifts up each time
    write_k(7'd3);
    value_pending_q = '{3, 2, 1, 2, 2};
    drain_all();

    for (int p = 0; p < 12; p++) begin
      write_k(k_plan[p]);
      set_mode(p % 4);
      if (p == 6) rx_hold = LongHold;
      for (int i = 0; i < PhaseItems; i++) value_pending_q.push_back(random_value());
      drain_all();
    end

    $display("run covered %0d words, %0d k writes (0, 1, 2..127 incl. saturation),",
             n_words, n_kwrites);
    $display("%0d results checked, %0d with a full heap, under four idle/stall mixes",
             n_results, n_full);
    if (n_errors == 0 && kth_expected_q.size() == 0) begin
      $display("** kth_largest_stream_tracker_unit: PASSED **");
    end else begin
      $display("** kth_largest_stream_tracker_unit: FAILED **");
    end
    $finish;
  end

endmodule
